>>> rtl/lrutlb_pkg.sv
package lrutlb_pkg;

   localparam int PAGE_WIDTH  = 64;
   localparam int COUNT_WIDTH = 32;
   localparam int CFG_WIDTH   = 7;

   localparam logic [CFG_WIDTH-1:0]   TLB_ENTRIES_RESET = 7'd64;
   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX         = 32'hFFFF_FFFF;

   typedef struct packed {
      logic capture;
      logic update;
   } ctrl_type;

endpackage

>>> rtl/lrutlb_cell.sv
module lrutlb_cell #(
   parameter int IDX = 0,
   parameter int IW  = 7
) (
   input  logic                              clock,
   input  lrutlb_pkg::ctrl_type              ctrl,
   input  logic [lrutlb_pkg::PAGE_WIDTH-1:0] lookup_page,
   input  logic [IW-1:0]                     valid_limit,
   input  logic [IW-1:0]                     stop_pos,
   input  logic                              shift_in,
   input  logic [lrutlb_pkg::PAGE_WIDTH-1:0] left_page,
   output logic [lrutlb_pkg::PAGE_WIDTH-1:0] page_out,
   output logic                              match,
   output logic                              shift_out
);

   logic [lrutlb_pkg::PAGE_WIDTH-1:0] page_ff;
   logic                              match_ff;
   logic                              match_in;
   logic                              stop;

   assign match_in  = (page_ff == lookup_page) && (IW'(IDX) < valid_limit);
   assign stop      = match_ff || (stop_pos == IW'(IDX));
   assign shift_out = shift_in && !stop;
   assign page_out  = page_ff;
   assign match     = match_ff;

   always_ff @(posedge clock) begin
      if (ctrl.capture) begin
         match_ff <= match_in;
      end
      if (ctrl.update && shift_in) begin
         page_ff <= left_page;
      end
   end

endmodule

>>> rtl/lru_tlb_hit_counter.sv
// Fully associative TLB with LRU replacement and a saturating hit counter.
// Requests arrive on the req_ channel (valid/stall) and carry a page number
// and a last-in-trace flag. Each request yields exactly one response on the
// rsp_ channel with the hit flag, the running hit count and trace_done.
// The pages sit in a row of cells ordered from most to least recent; every
// cell compares its page in the accept cycle; in the update step, once the
// response register is free, the row shifts one place from the front up to
// the hit or insertion point, and the response is registered. A new request
// is accepted only after the previous one has finished this compare then
// shift pass through the cell row. The response register lets the next
// request enter while a response is still waiting. If the receiver stalls while
// a second response is ready, the block holds it and stalls the request side.
// csr_write_enable writes the number of entries in use (reset value 64).
// Reset is synchronous and empties the TLB and clears the hit counter;
// the cell contents themselves are not cleared.
module lru_tlb_hit_counter #(
   parameter int MAX_ENTRIES = 64
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [lrutlb_pkg::PAGE_WIDTH-1:0]  req_page_number,
   input  logic                               req_last_in_trace,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic                               rsp_hit,
   output logic [lrutlb_pkg::COUNT_WIDTH-1:0] rsp_hit_count,
   output logic                               rsp_trace_done,
   input  logic                               csr_write_enable,
   input  logic [lrutlb_pkg::CFG_WIDTH-1:0]   csr_write_data
);

   localparam int IW = $clog2(MAX_ENTRIES + 1);
   localparam int CW = (IW > lrutlb_pkg::CFG_WIDTH) ? IW : lrutlb_pkg::CFG_WIDTH;

   typedef enum logic {
      ST_IDLE,
      ST_UPDATE
   } state_type;

   state_type                          state_ff;
   logic [lrutlb_pkg::CFG_WIDTH-1:0]   tlb_entries_ff;
   logic [IW-1:0]                      valid_ff;
   logic [lrutlb_pkg::COUNT_WIDTH-1:0] hits_ff;
   logic [IW-1:0]                      limit_ff;
   logic [IW-1:0]                      pos_ff;
   logic [lrutlb_pkg::PAGE_WIDTH-1:0]  page_ff;
   logic                               last_ff;
   logic                               rsp_valid_ff;
   logic                               rsp_hit_ff;
   logic [lrutlb_pkg::COUNT_WIDTH-1:0] rsp_hit_count_ff;
   logic                               rsp_trace_done_ff;

   logic [CW-1:0]                      tlb_ext;
   logic [IW-1:0]                      cap;
   logic [IW-1:0]                      valid_eff;
   logic [IW-1:0]                      pos_miss;
   logic                               rsp_free;
   logic                               found;
   logic [lrutlb_pkg::COUNT_WIDTH-1:0] hits_in;
   logic [IW-1:0]                      valid_in;
   lrutlb_pkg::ctrl_type               ctrl;

   logic [lrutlb_pkg::PAGE_WIDTH-1:0]  page_chain [MAX_ENTRIES];
   logic [MAX_ENTRIES:0]               shift_chain;
   logic [MAX_ENTRIES-1:0]             match_bits;

   assign tlb_ext = CW'(tlb_entries_ff);

   always_comb begin
      priority if (tlb_entries_ff == '0) begin
         cap = IW'(1);
      end else if (tlb_ext > CW'(MAX_ENTRIES)) begin
         cap = IW'(MAX_ENTRIES);
      end else begin
         cap = IW'(tlb_ext);
      end
   end

   assign valid_eff = (valid_ff > cap) ? cap : valid_ff;
   assign pos_miss  = (valid_eff >= cap) ? (cap - IW'(1)) : valid_eff;

   assign req_stall    = (state_ff != ST_IDLE);
   assign rsp_free     = !rsp_valid_ff || !rsp_stall;
   assign ctrl.capture = req_valid && (state_ff == ST_IDLE);
   assign ctrl.update  = (state_ff == ST_UPDATE) && rsp_free;

   assign found    = |match_bits;
   assign hits_in  = (found && (hits_ff != lrutlb_pkg::COUNT_MAX)) ?
                     (hits_ff + lrutlb_pkg::COUNT_WIDTH'(1)) : hits_ff;
   assign valid_in = found ? limit_ff : (pos_ff + IW'(1));

   assign page_chain[0]  = page_ff;
   assign shift_chain[0] = 1'b1;

   for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
      if (i < MAX_ENTRIES - 1) begin : g_mid
         lrutlb_cell #(
            .IDX (i),
            .IW  (IW)
         ) u_cell (
            .clock       (clock),
            .ctrl        (ctrl),
            .lookup_page (req_page_number),
            .valid_limit (valid_eff),
            .stop_pos    (pos_ff),
            .shift_in    (shift_chain[i]),
            .left_page   (page_chain[i]),
            .page_out    (page_chain[i+1]),
            .match       (match_bits[i]),
            .shift_out   (shift_chain[i+1])
         );
      end else begin : g_end
         lrutlb_cell #(
            .IDX (i),
            .IW  (IW)
         ) u_cell (
            .clock       (clock),
            .ctrl        (ctrl),
            .lookup_page (req_page_number),
            .valid_limit (valid_eff),
            .stop_pos    (pos_ff),
            .shift_in    (shift_chain[i]),
            .left_page   (page_chain[i]),
            .page_out    (),
            .match       (match_bits[i]),
            .shift_out   (shift_chain[i+1])
         );
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tlb_entries_ff <= lrutlb_pkg::TLB_ENTRIES_RESET;
      end else if (csr_write_enable) begin
         tlb_entries_ff <= csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         valid_ff     <= '0;
         hits_ff      <= '0;
      end else begin
         if (rsp_valid_ff && !rsp_stall && !ctrl.update) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  page_ff  <= req_page_number;
                  last_ff  <= req_last_in_trace;
                  limit_ff <= valid_eff;
                  pos_ff   <= pos_miss;
                  state_ff <= ST_UPDATE;
               end
            end
            ST_UPDATE: begin
               if (rsp_free) begin
                  rsp_valid_ff      <= 1'b1;
                  rsp_hit_ff        <= found;
                  rsp_hit_count_ff  <= hits_in;
                  rsp_trace_done_ff <= last_ff;
                  valid_ff          <= last_ff ? '0 : valid_in;
                  hits_ff           <= last_ff ? '0 : hits_in;
                  state_ff          <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_hit        = rsp_hit_ff;
   assign rsp_hit_count  = rsp_hit_count_ff;
   assign rsp_trace_done = rsp_trace_done_ff;

   a_shift_stops_in_row: assert property (@(posedge clock) disable iff (reset)
      ctrl.update |-> !shift_chain[MAX_ENTRIES])
      else $error("shift ran past the last cell");

   a_single_match: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_UPDATE) |-> ($countones(match_bits) <= 1))
      else $error("page resident in more than one cell");

   a_valid_in_range: assert property (@(posedge clock) disable iff (reset)
      valid_ff <= IW'(MAX_ENTRIES))
      else $error("resident count above capacity");

   a_rsp_after_update: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_UPDATE))
      else $error("response raised outside the update step");

endmodule

>>> tb/lru_tlb_checker.sv
module lru_tlb_checker #(
   parameter int MAX_ENTRIES = 64
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   input  logic                               req_stall,
   input  logic [lrutlb_pkg::PAGE_WIDTH-1:0]  req_page_number,
   input  logic                               req_last_in_trace,
   input  logic                               rsp_valid,
   input  logic                               rsp_stall,
   input  logic                               rsp_hit,
   input  logic [lrutlb_pkg::COUNT_WIDTH-1:0] rsp_hit_count,
   input  logic                               rsp_trace_done,
   input  logic                               csr_write_enable,
   input  logic [lrutlb_pkg::CFG_WIDTH-1:0]   csr_write_data,
   output int                                 fail_count,
   output int                                 pending_count
);

   typedef struct packed {
      logic                               hit;
      logic [lrutlb_pkg::COUNT_WIDTH-1:0] hit_count;
      logic                               trace_done;
   } lookup_result_type;

   logic [lrutlb_pkg::PAGE_WIDTH-1:0]  lru_pages [MAX_ENTRIES];
   int                                 resident;
   logic [lrutlb_pkg::COUNT_WIDTH-1:0] hit_tally;
   logic [lrutlb_pkg::CFG_WIDTH-1:0]   entries_setting;
   lookup_result_type                  expected_lookups [$];
   int                                 response_total;

   initial begin
      fail_count     = 0;
      pending_count  = 0;
      response_total = 0;
   end

   function automatic lookup_result_type lookup_and_promote(
      input logic [lrutlb_pkg::PAGE_WIDTH-1:0] page,
      input logic                              last);
      int                span;
      int                pos;
      int                k;
      logic              found;
      lookup_result_type outcome;
      span  = (entries_setting == 0) ? 1 :
              ((entries_setting > MAX_ENTRIES) ? MAX_ENTRIES : int'(entries_setting));
      found = 1'b0;
      pos   = 0;
      if (resident > span) begin
         resident = span;
      end
      for (k = 0; k < resident; k++) begin
         if (!found && lru_pages[k] == page) begin
            found = 1'b1;
            pos   = k;
         end
      end
      if (found) begin
         if (hit_tally != lrutlb_pkg::COUNT_MAX) begin
            hit_tally = hit_tally + 1'b1;
         end
      end else begin
         if (resident >= span) begin
            resident = span - 1;
         end
         pos      = resident;
         resident = resident + 1;
      end
      for (k = pos; k > 0; k--) begin
         lru_pages[k] = lru_pages[k-1];
      end
      lru_pages[0]       = page;
      outcome.hit        = found;
      outcome.hit_count  = hit_tally;
      outcome.trace_done = last;
      if (last) begin
         resident  = 0;
         hit_tally = '0;
      end
      return outcome;
   endfunction

   function automatic void flag_failure(input string msg);
      fail_count++;
      if (fail_count <= 10) begin
         $display("%s", msg);
      end
   endfunction

   always @(posedge clock) begin
      lookup_result_type observed;
      lookup_result_type predicted;
      if (reset) begin
         resident        = 0;
         hit_tally       = '0;
         entries_setting = lrutlb_pkg::TLB_ENTRIES_RESET;
         expected_lookups.delete();
      end else begin
         if (csr_write_enable) begin
            entries_setting = csr_write_data;
         end
         if (rsp_valid && !rsp_stall) begin
            observed.hit        = rsp_hit;
            observed.hit_count  = rsp_hit_count;
            observed.trace_done = rsp_trace_done;
            if (expected_lookups.size() == 0) begin
               flag_failure($sformatf("Response %0d arrived with no request outstanding: %s",
                                      response_total,
                                      $sformatf("hit=%0b hit_count=%0d trace_done=%0b",
                                                rsp_hit, rsp_hit_count, rsp_trace_done)));
            end else begin
               predicted = expected_lookups.pop_front();
               if (observed !== predicted) begin
                  flag_failure($sformatf(
                     "Response %0d mismatch: expected hit=%0b hit_count=%0d trace_done=%0b, %s",
                     response_total, predicted.hit, predicted.hit_count,
                     predicted.trace_done,
                     $sformatf("got hit=%0b hit_count=%0d trace_done=%0b",
                               rsp_hit, rsp_hit_count, rsp_trace_done)));
               end
            end
            response_total++;
         end
         if (req_valid && !req_stall) begin
            expected_lookups.push_back(lookup_and_promote(req_page_number, req_last_in_trace));
         end
      end
      pending_count = expected_lookups.size();
   end

endmodule

>>> tb/tb_lru_tlb_hit_counter.sv
module tb_lru_tlb_hit_counter;

   localparam int TLB_DEPTH   = 64;
   localparam int CYCLE_LIMIT = 400000;
   localparam int PHASE_ITEMS = 156;

   logic                               clock = 1'b0;
   logic                               reset;
   logic                               req_valid;
   logic                               req_stall;
   logic [lrutlb_pkg::PAGE_WIDTH-1:0]  req_page_number;
   logic                               req_last_in_trace;
   logic                               rsp_valid;
   logic                               rsp_stall;
   logic                               rsp_hit;
   logic [lrutlb_pkg::COUNT_WIDTH-1:0] rsp_hit_count;
   logic                               rsp_trace_done;
   logic                               csr_write_enable;
   logic [lrutlb_pkg::CFG_WIDTH-1:0]   csr_write_data;
   int                                 fail_count;
   int                                 pending_count;

   logic                               idling_on = 1'b1;
   int unsigned                        cycle_count = 0;
   int                                 request_total = 0;
   int                                 trace_total = 0;
   int                                 setting_total = 0;
   int                                 entries_plan [12] = '{64, 1, 0, 127, 65, 2, 5, 16, 33,
                                                             63, 100, 0};
   logic [lrutlb_pkg::PAGE_WIDTH-1:0]  page_pool [$];

   lru_tlb_hit_counter #(.MAX_ENTRIES(TLB_DEPTH)) dut (.*);

   lru_tlb_checker #(.MAX_ENTRIES(TLB_DEPTH)) u_checker (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (idling_on && $urandom_range(0, 7) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 13)) @(negedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // Called at a falling edge; returns at a falling edge after the request is taken.
   task automatic send_request(input logic [63:0] page, input logic last);
      req_valid         <= 1'b1;
      req_page_number   <= page;
      req_last_in_trace <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
      request_total++;
      if (last) begin
         trace_total++;
      end
      if (idling_on && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(negedge clock);
      end
   endtask

   task automatic drain_responses();
      req_valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_entries(input int value);
      drain_responses();
      csr_write_enable <= 1'b1;
      csr_write_data   <= value[lrutlb_pkg::CFG_WIDTH-1:0];
      @(negedge clock);
      csr_write_enable <= 1'b0;
      setting_total++;
   endtask

   task automatic run_random_phase(input int setting, input int items);
      int                                span;
      int                                pool_size;
      int                                choice;
      int                                i;
      logic [lrutlb_pkg::PAGE_WIDTH-1:0] page;
      span      = (setting == 0) ? 1 : ((setting > TLB_DEPTH) ? TLB_DEPTH : setting);
      pool_size = span + $urandom_range(0, span);
      page_pool.delete();
      for (i = 0; i < pool_size; i++) begin
         page_pool.push_back({$urandom, $urandom});
      end
      for (i = 0; i < items; i++) begin
         choice = $urandom_range(0, 99);
         page   = page_pool[$urandom_range(0, pool_size - 1)];
         if (choice >= 97) begin
            page = page ^ (64'h1 << $urandom_range(0, 31));
         end else if (choice >= 94) begin
            page = ($urandom_range(0, 1) == 1) ? '1 : '0;
         end else if (choice >= 88) begin
            page = page ^ (64'h1 << $urandom_range(32, 63));
         end else if (choice >= 80) begin
            page = {$urandom, $urandom};
         end
         send_request(page, $urandom_range(0, 59) == 0);
      end
   endtask

   initial begin
      int                                p;
      int                                k;
      int                                value;
      logic [lrutlb_pkg::PAGE_WIDTH-1:0] step_page;
      reset             = 1'b1;
      req_valid         = 1'b0;
      req_page_number   = '0;
      req_last_in_trace = 1'b0;
      csr_write_enable  = 1'b0;
      csr_write_data    = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Full 64-bit compare, a trace end and the restart after it, at the reset capacity.
      send_request(64'h0, 1'b0);
      send_request(64'h0, 1'b0);
      send_request('1, 1'b0);
      send_request(64'h0000_0001_0000_0000, 1'b0);
      send_request(64'h8000_0000_0000_0000, 1'b0);
      send_request('1, 1'b0);
      send_request(64'h0, 1'b1);
      send_request(64'h0, 1'b0);
      send_request(64'h0, 1'b1);

      write_entries(1);
      send_request(64'h5555_5555_5555_5555, 1'b0);
      send_request(64'h5555_5555_5555_5555, 1'b0);
      send_request(64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
      send_request(64'h5555_5555_5555_5555, 1'b0);

      // A setting of zero behaves as a single entry.
      write_entries(0);
      send_request(64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
      send_request(64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
      send_request(64'h5555_5555_5555_5555, 1'b1);

      // Shrinking the capacity mid-trace drops the least recent pages.
      write_entries(8);
      step_page = 64'h0123_4567_89AB_CDEF;
      for (k = 0; k < 6; k++) begin
         send_request(step_page + 64'(k), 1'b0);
      end
      write_entries(3);
      send_request(step_page + 64'd5, 1'b0);
      send_request(step_page, 1'b1);

      for (p = 0; p < 12; p++) begin
         value = (p == 11) ? $urandom_range(0, 127) : entries_plan[p];
         write_entries(value);
         if (p == 11) begin
            idling_on = 1'b0;
         end
         run_random_phase(value, PHASE_ITEMS);
      end

      drain_responses();
      repeat (6) @(negedge clock);
      $display("Ran %0d requests in %0d completed traces over %0d capacity settings,",
               request_total, trace_total, setting_total);
      $display("including zero, oversized and mid-trace reduced capacities.");
      if (fail_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

>>> files.f
rtl/lrutlb_pkg.sv
rtl/lrutlb_cell.sv
rtl/lru_tlb_hit_counter.sv
tb/lru_tlb_checker.sv
tb/tb_lru_tlb_hit_counter.sv
